FILE: hw/rtl/thp_pkg.sv
// shared types and constants for the sensor compensation core
package thp_pkg;

  localparam int DIV_W      = 64;
  localparam int Q_DEPTH    = 4;
  localparam int Q_AW       = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CW       = $clog2(Q_DEPTH + 1);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic signed [33:0] P_TFINE_OFS = 34'sd128000;
  localparam logic [20:0]        P_RAW_FULL  = 21'd1048576;
  localparam logic signed [63:0] P_SCALE     = 64'sd3125;
  localparam logic signed [31:0] H_TFINE_OFS = 32'sd76800;
  localparam logic signed [31:0] H_MAX       = 32'sd419430400;
  localparam logic signed [31:0] H_W_OFS     = 32'sd2097152;
  localparam logic signed [31:0] H_X_RND     = 32'sd16384;
  localparam logic signed [31:0] H_W_RND     = 32'sd8192;
  localparam logic signed [31:0] H_Z_OFS     = 32'sd32768;
  localparam logic [16:0]        HUM_OUT_MAX = 17'd102400;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TEMP_CAL  = 3'd0,
    CFG_PRESS_LO  = 3'd1,
    CFG_PRESS_HI  = 3'd2,
    CFG_MIXED_CAL = 3'd3,
    CFG_HUM_CAL   = 3'd4
  } thp_cfg_idx_t;

  typedef struct packed {
    logic [47:0] temp_cal;
    logic [63:0] press_lo;
    logic [63:0] press_hi;
    logic [47:0] mixed;
    logic [31:0] hum;
  } thp_cal_t;

  typedef struct packed {
    logic signed [31:0] tfine;
    logic signed [31:0] temp;
    logic [19:0]        adc_p;
    logic [15:0]        adc_h;
  } thp_sample_t;

  typedef struct packed {
    logic signed [31:0] temp;
    logic [16:0]        hum;
    logic               dz;
  } thp_side_t;

endpackage

FILE: hw/rtl/thp_if.sv
// input and result channel interfaces
interface thp_in_if;
  logic        valid;
  logic        ready;
  logic [19:0] raw_temperature;
  logic [19:0] raw_pressure;
  logic [15:0] raw_humidity;

  modport source(output valid, raw_temperature, raw_pressure, raw_humidity, input ready);
  modport sink(input valid, raw_temperature, raw_pressure, raw_humidity, output ready);
endinterface

interface thp_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] temperature_centi;
  logic [31:0]        pressure_q24_8;
  logic [16:0]        humidity_q22_10;
  logic               divisor_zero;

  modport source(output valid, temperature_centi, pressure_q24_8, humidity_q22_10,
                 divisor_zero, input ready);
  modport sink(input valid, temperature_centi, pressure_q24_8, humidity_q22_10,
               divisor_zero, output ready);
endinterface

FILE: hw/rtl/thp_front.sv
// front pipeline: temperature and fine temperature per sample
module thp_front (
  input  logic                clk,
  input  logic                rst_n,
  input  thp_pkg::thp_cal_t   cal,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [19:0]         raw_t,
  input  logic [19:0]         raw_p,
  input  logic [15:0]         raw_h,
  input  logic                q_full,
  output logic                q_push,
  output thp_pkg::thp_sample_t q_wdata
);

  logic [3:0]         fv_r;
  logic               en;
  logic [15:0]        t1;
  logic signed [15:0] t2;
  logic signed [15:0] t3;
  logic signed [31:0] a_c;
  logic signed [31:0] d_c;

  logic signed [31:0] m1_r, dd_r, v1t_r, m2_r, tfine3_r, tfine4_r, temp_r;
  logic [19:0]        p1_r, p2_r, p3_r, p4_r;
  logic [15:0]        h1_r, h2_r, h3_r, h4_r;

  assign t1 = cal.temp_cal[15:0];
  assign t2 = $signed(cal.temp_cal[31:16]);
  assign t3 = $signed(cal.temp_cal[47:32]);

  assign a_c = $signed({15'b0, raw_t[19:3]} - {15'b0, t1, 1'b0});
  assign d_c = $signed({16'b0, raw_t[19:4]} - {16'b0, t1});

  assign en       = !(fv_r[3] && q_full);
  assign in_ready = en;
  assign q_push   = fv_r[3] && !q_full;
  assign q_wdata  = '{tfine: tfine4_r, temp: temp_r, adc_p: p4_r, adc_h: h4_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= '0;
    end else if (en) begin
      fv_r <= {fv_r[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_r     <= a_c * t2;
      dd_r     <= d_c * d_c;
      p1_r     <= raw_p;
      h1_r     <= raw_h;
      v1t_r    <= m1_r >>> 11;
      m2_r     <= (dd_r >>> 12) * t3;
      p2_r     <= p1_r;
      h2_r     <= h1_r;
      tfine3_r <= v1t_r + (m2_r >>> 14);
      p3_r     <= p2_r;
      h3_r     <= h2_r;
      tfine4_r <= tfine3_r;
      temp_r   <= (tfine3_r * 32'sd5 + 32'sd128) >>> 8;
      p4_r     <= p3_r;
      h4_r     <= h3_r;
    end
  end

endmodule

FILE: hw/rtl/thp_queue.sv
// small queue between front and back
module thp_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  thp_pkg::thp_sample_t wdata,
  input  logic                 pop,
  output thp_pkg::thp_sample_t rdata,
  output logic                 full,
  output logic                 empty
);

  thp_pkg::thp_sample_t        mem_r [thp_pkg::Q_DEPTH];
  logic [thp_pkg::Q_AW-1:0]    wp_r, rp_r, wp_nxt, rp_nxt;
  logic [thp_pkg::Q_CW-1:0]    cnt_r;

  assign wp_nxt = (wp_r == thp_pkg::Q_AW'(thp_pkg::Q_DEPTH - 1)) ? '0 : wp_r + 1'b1;
  assign rp_nxt = (rp_r == thp_pkg::Q_AW'(thp_pkg::Q_DEPTH - 1)) ? '0 : rp_r + 1'b1;
  assign full   = (cnt_r == thp_pkg::Q_CW'(thp_pkg::Q_DEPTH));
  assign empty  = (cnt_r == '0);
  assign rdata  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_nxt;
      if (pop) rp_r <= rp_nxt;
      cnt_r <= cnt_r + thp_pkg::Q_CW'(push) - thp_pkg::Q_CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wdata;
    end
  end

endmodule

FILE: hw/rtl/thp_div.sv
// pipelined signed divider, one quotient bit per stage
module thp_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_v,
  input  logic signed [thp_pkg::DIV_W-1:0] num,
  input  logic signed [thp_pkg::DIV_W-1:0] den,
  input  thp_pkg::thp_side_t            side_in,
  output logic                          out_v,
  output logic signed [thp_pkg::DIV_W-1:0] quot,
  output thp_pkg::thp_side_t            side_out
);

  localparam int W = thp_pkg::DIV_W;

  logic [W:0]         vd_r;
  logic [W-1:0]       mn_r  [0:W];
  logic [W-1:0]       md_r  [0:W];
  logic [W-1:0]       rem_r [0:W];
  logic [W-1:0]       q_r   [0:W];
  logic               neg_r [0:W];
  thp_pkg::thp_side_t side_r [0:W];

  logic [W-1:0]       rem_nxt [1:W];
  logic [W-1:0]       q_nxt   [1:W];
  logic               out_v_r;
  logic signed [W-1:0] quot_r;
  thp_pkg::thp_side_t side_out_r;

  always_comb begin
    logic [W:0] rs;
    logic       ge;
    for (int k = 1; k <= W; k++) begin
      rs = {rem_r[k-1], mn_r[k-1][W-1]};
      ge = (rs >= {1'b0, md_r[k-1]});
      rem_nxt[k] = ge ? W'(rs - {1'b0, md_r[k-1]}) : rs[W-1:0];
      q_nxt[k]   = {q_r[k-1][W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r    <= '0;
      out_v_r <= 1'b0;
    end else if (en) begin
      vd_r    <= {vd_r[W-1:0], in_v};
      out_v_r <= vd_r[W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mn_r[0]   <= num[W-1] ? W'(-num) : num;
      md_r[0]   <= den[W-1] ? W'(-den) : den;
      rem_r[0]  <= '0;
      q_r[0]    <= '0;
      neg_r[0]  <= num[W-1] ^ den[W-1];
      side_r[0] <= side_in;
      for (int k = 1; k <= W; k++) begin
        mn_r[k]   <= {mn_r[k-1][W-2:0], 1'b0};
        md_r[k]   <= md_r[k-1];
        rem_r[k]  <= rem_nxt[k];
        q_r[k]    <= q_nxt[k];
        neg_r[k]  <= neg_r[k-1];
        side_r[k] <= side_r[k-1];
      end
      quot_r     <= neg_r[W] ? $signed(W'(-q_r[W])) : $signed(q_r[W]);
      side_out_r <= side_r[W];
    end
  end

  assign out_v    = out_v_r;
  assign quot     = quot_r;
  assign side_out = side_out_r;

endmodule

FILE: hw/rtl/thp_back.sv
// back pipeline: pressure and humidity, divider, result register
module thp_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  thp_pkg::thp_cal_t    cal,
  input  logic                 q_empty,
  input  thp_pkg::thp_sample_t q_rdata,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [31:0]   out_temp,
  output logic [31:0]          out_pres,
  output logic [16:0]          out_hum,
  output logic                 out_dz
);

  logic en;
  logic [10:0] sv_r;
  logic [4:0]  uv_r;

  // calibration fields
  logic signed [16:0] p1;
  logic signed [15:0] p2, p3, p5, p6, p8, p9, h2;
  logic signed [63:0] p4w, p7w;
  logic signed [8:0]  h1, h3;
  logic signed [11:0] h5;
  logic signed [7:0]  h6;

  assign p1  = $signed({1'b0, cal.press_lo[15:0]});
  assign p2  = $signed(cal.press_lo[31:16]);
  assign p3  = $signed(cal.press_lo[47:32]);
  assign p4w = 64'($signed(cal.press_lo[63:48]));
  assign p5  = $signed(cal.press_hi[15:0]);
  assign p6  = $signed(cal.press_hi[31:16]);
  assign p7w = 64'($signed(cal.press_hi[47:32]));
  assign p8  = $signed(cal.press_hi[63:48]);
  assign p9  = $signed(cal.mixed[15:0]);
  assign h1  = $signed({1'b0, cal.mixed[23:16]});
  assign h2  = $signed(cal.mixed[39:24]);
  assign h3  = $signed({1'b0, cal.mixed[47:40]});
  assign h5  = $signed(cal.hum[23:12]);
  assign h6  = $signed(cal.hum[31:24]);

  assign en    = !uv_r[4] || out_ready;
  assign q_pop = en && !q_empty;

  // pre-divide stages
  logic signed [33:0] v1p_r;
  logic signed [31:0] vh_r, hv5_r, hy_r, hz_r, x_r, y_r, z_r, yz_r, w_r, wh_r, w2_r;
  logic signed [31:0] x4_r, x5_r, x6_r, x7_r, hv_r, hv10_r, hv11_r, ss_r, t_r;
  logic signed [63:0] sq_r, m5_r, m2_r, v2a_r, v1a_r, m5b_r, m2b_r, v2_r, v1b_r;
  logic signed [63:0] v1c_r, n0_r, v1d_r, n1_r, den_r;
  logic signed [63:0] n1_8_r, n1_9_r, n1_10_r, n1_11_r, n1_12_r;
  logic signed [63:0] den8_r, den9_r, den10_r, den11_r;
  logic [19:0]        ap1_r, ap2_r, ap3_r, ap4_r;
  logic [15:0]        ah1_r, ah2_r;
  logic signed [31:0] tmp_r [1:11];
  logic [16:0]        hum_r;
  logic               dz_r;

  logic signed [31:0] xt_c, sh_c, vf_c;
  logic [20:0]        pm_c;
  logic [16:0]        hum_c;

  assign xt_c = $signed({2'b00, ah2_r, 14'b0}) - $signed({cal.hum[11:0], 20'b0})
                - hv5_r + thp_pkg::H_X_RND;
  assign pm_c = thp_pkg::P_RAW_FULL - {1'b0, ap4_r};
  assign sh_c = hv_r >>> 15;
  assign vf_c = hv11_r - (t_r >>> 4);

  always_comb begin
    if (vf_c[31]) begin
      hum_c = '0;
    end else if (vf_c > thp_pkg::H_MAX) begin
      hum_c = thp_pkg::HUM_OUT_MAX;
    end else begin
      hum_c = vf_c[28:12];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r <= '0;
    end else if (en) begin
      sv_r <= {sv_r[9:0], !q_empty};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // s1
      v1p_r    <= 34'(q_rdata.tfine) - thp_pkg::P_TFINE_OFS;
      vh_r     <= q_rdata.tfine - thp_pkg::H_TFINE_OFS;
      tmp_r[1] <= q_rdata.temp;
      ap1_r    <= q_rdata.adc_p;
      ah1_r    <= q_rdata.adc_h;
      // s2
      sq_r  <= v1p_r * v1p_r;
      m5_r  <= v1p_r * p5;
      m2_r  <= v1p_r * p2;
      hv5_r <= h5 * vh_r;
      hy_r  <= vh_r * h6;
      hz_r  <= vh_r * h3;
      ap2_r <= ap1_r;
      ah2_r <= ah1_r;
      // s3
      v2a_r <= sq_r * p6;
      v1a_r <= sq_r * p3;
      m5b_r <= m5_r;
      m2b_r <= m2_r;
      x_r   <= xt_c >>> 15;
      y_r   <= hy_r >>> 10;
      z_r   <= (hz_r >>> 11) + thp_pkg::H_Z_OFS;
      ap3_r <= ap2_r;
      // s4
      v2_r  <= v2a_r + (m5b_r <<< 17) + (p4w <<< 35);
      v1b_r <= (v1a_r >>> 8) + (m2b_r <<< 12);
      yz_r  <= y_r * z_r;
      x4_r  <= x_r;
      ap4_r <= ap3_r;
      // s5
      v1c_r <= v1b_r + (64'sd1 <<< 47);
      n0_r  <= $signed({12'b0, pm_c, 31'b0}) - v2_r;
      w_r   <= (yz_r >>> 10) + thp_pkg::H_W_OFS;
      x5_r  <= x4_r;
      // s6
      v1d_r <= v1c_r * p1;
      n1_r  <= n0_r * thp_pkg::P_SCALE;
      wh_r  <= w_r * h2;
      x6_r  <= x5_r;
      // s7
      den_r  <= v1d_r >>> 33;
      n1_8_r <= n1_r;
      w2_r   <= (wh_r + thp_pkg::H_W_RND) >>> 14;
      x7_r   <= x6_r;
      // s8
      hv_r   <= x7_r * w2_r;
      den8_r <= den_r;
      n1_9_r <= n1_8_r;
      // s9
      ss_r    <= sh_c * sh_c;
      hv10_r  <= hv_r;
      den9_r  <= den8_r;
      n1_10_r <= n1_9_r;
      // s10
      t_r     <= (ss_r >>> 7) * h1;
      hv11_r  <= hv10_r;
      den10_r <= den9_r;
      n1_11_r <= n1_10_r;
      // s11
      hum_r   <= hum_c;
      dz_r    <= (den10_r == '0);
      den11_r <= den10_r;
      n1_12_r <= n1_11_r;
      for (int k = 2; k <= 11; k++) begin
        tmp_r[k] <= tmp_r[k-1];
      end
    end
  end

  // divider
  logic               dv_v;
  logic signed [63:0] quot;
  thp_pkg::thp_side_t dv_side;

  thp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (sv_r[10]),
    .num      (n1_12_r),
    .den      (den11_r),
    .side_in  ('{temp: tmp_r[11], hum: hum_r, dz: dz_r}),
    .out_v    (dv_v),
    .quot     (quot),
    .side_out (dv_side)
  );

  // post-divide stages
  logic signed [63:0] q1_r, q2_r, q3_r, m9_r, w2p1_r, w2p2_r, w2p3_r, w1f_r, sum_r, ps_c;
  logic [63:0]        ll_r;
  logic [31:0]        lh_r, hl_r, pres_r;
  thp_pkg::thp_side_t sd_r [1:5];
  logic [31:0]        pres_c;

  assign ps_c   = q1_r >>> 13;
  assign pres_c = sd_r[4].dz ? '0 : 32'((sum_r >>> 8) + (p7w <<< 4));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      uv_r <= '0;
    end else if (en) begin
      uv_r <= {uv_r[3:0], dv_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q1_r   <= quot;
      m9_r   <= p9 * (quot >>> 13);
      w2p1_r <= quot * p8;
      q2_r   <= q1_r;
      w2p2_r <= w2p1_r;
      ll_r   <= m9_r[31:0] * ps_c[31:0];
      lh_r   <= m9_r[31:0] * ps_c[63:32];
      hl_r   <= m9_r[63:32] * ps_c[31:0];
      q3_r   <= q2_r;
      w2p3_r <= w2p2_r;
      w1f_r  <= $signed(ll_r + {32'(lh_r + hl_r), 32'b0});
      sum_r  <= q3_r + (w1f_r >>> 25) + (w2p3_r >>> 19);
      pres_r <= pres_c;
      sd_r[1] <= dv_side;
      for (int k = 2; k <= 5; k++) begin
        sd_r[k] <= sd_r[k-1];
      end
    end
  end

  assign out_valid = uv_r[4];
  assign out_temp  = sd_r[5].temp;
  assign out_hum   = sd_r[5].hum;
  assign out_dz    = sd_r[5].dz;
  assign out_pres  = pres_r;

endmodule

FILE: hw/rtl/thp_sensor_compensation_core.sv
// throughput: one sample per cycle while the output is not stalled;
// the 64-stage one-bit-per-stage divider sets the depth
// a four-entry queue between the temperature front and the pressure/humidity back
// reset clears all valid bits, queue pointers and calibration registers to zero
// top level: calibration registers, front, queue and back
module thp_sensor_compensation_core (
  input  logic                              clk,
  input  logic                              rst_n,
  thp_in_if.sink                            in_ch,
  thp_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [thp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [thp_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  thp_pkg::thp_cal_t    cal_r;
  thp_pkg::thp_sample_t q_wdata, q_rdata;
  logic                 q_push, q_pop, q_full, q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        thp_pkg::CFG_TEMP_CAL:  cal_r.temp_cal <= cfg_wdata[47:0];
        thp_pkg::CFG_PRESS_LO:  cal_r.press_lo <= cfg_wdata;
        thp_pkg::CFG_PRESS_HI:  cal_r.press_hi <= cfg_wdata;
        thp_pkg::CFG_MIXED_CAL: cal_r.mixed    <= cfg_wdata[47:0];
        thp_pkg::CFG_HUM_CAL:   cal_r.hum      <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  thp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cal      (cal_r),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .raw_t    (in_ch.raw_temperature),
    .raw_p    (in_ch.raw_pressure),
    .raw_h    (in_ch.raw_humidity),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  thp_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  thp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cal       (cal_r),
    .q_empty   (q_empty),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_temp  (out_ch.temperature_centi),
    .out_pres  (out_ch.pressure_q24_8),
    .out_hum   (out_ch.humidity_q22_10),
    .out_dz    (out_ch.divisor_zero)
  );

endmodule

FILE: hw/rtl/thp_checker.sv
// port checker for the compensation core and its bind
module thp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_pres,
  input logic [16:0] out_hum,
  input logic        out_dz
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_dz |-> out_pres == '0)
    else $error("divisor zero with nonzero pressure");

  a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_hum <= thp_pkg::HUM_OUT_MAX)
    else $error("humidity above clamp");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pres) && $stable(out_hum))
    else $error("stalled result changed");

endmodule

bind thp_sensor_compensation_core thp_checker u_thp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_pres  (out_ch.pressure_q24_8),
  .out_hum   (out_ch.humidity_q22_10),
  .out_dz    (out_ch.divisor_zero)
);

FILE: tb/sv/tb_thp_sensor_compensation_core.sv
// testbench for the sensor compensation core: directed and random samples checked against a predictor
module tb_thp_sensor_compensation_core;

  typedef struct packed {
    logic [31:0] temp;
    logic [31:0] pres;
    logic [16:0] hum;
    logic        dz;
  } comp_result_t;

  localparam logic [thp_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [thp_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [thp_pkg::CFG_DATA_W-1:0] cfg_wdata;

  thp_in_if  in_ch();
  thp_out_if out_ch();

  thp_sensor_compensation_core DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  logic [47:0] cal_temp;
  logic [63:0] cal_plo;
  logic [63:0] cal_phi;
  logic [47:0] cal_mix;
  logic [31:0] cal_hum;

  comp_result_t expected_q[$];
  int errors = 0;
  int src_idle_pct = 0;
  int snk_stall_pct = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic logic [31:0] asr32(logic [31:0] x, int n);
    return $signed(x) >>> n;
  endfunction

  function automatic logic [63:0] asr64(logic [63:0] x, int n);
    return $signed(x) >>> n;
  endfunction

  function automatic logic [63:0] sdiv64(logic [63:0] num, logic [63:0] den);
    logic [63:0] mn, md, q;
    mn = num[63] ? 64'd0 - num : num;
    md = den[63] ? 64'd0 - den : den;
    q = mn / md;
    return (num[63] != den[63]) ? 64'd0 - q : q;
  endfunction

  function automatic comp_result_t compensate(logic [19:0] adc_t, logic [19:0] adc_p,
                                              logic [15:0] adc_h);
    comp_result_t r;
    logic [31:0] t1, t2, t3, a, d, v1t, v2t, tfine, adt;
    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, v1, v2, p, ps, w1, w2, num;
    logic [31:0] h1, h2, h3, h4, h5, h6, v, x, y, z, w, s, adh;
    adt = {12'd0, adc_t};
    t1 = {16'd0, cal_temp[15:0]};
    t2 = {{16{cal_temp[31]}}, cal_temp[31:16]};
    t3 = {{16{cal_temp[47]}}, cal_temp[47:32]};
    a = (adt >> 3) - (t1 << 1);
    v1t = asr32(a * t2, 11);
    d = (adt >> 4) - t1;
    v2t = asr32(asr32(d * d, 12) * t3, 14);
    tfine = v1t + v2t;
    r.temp = asr32(tfine * 32'd5 + 32'd128, 8);

    p1 = {48'd0, cal_plo[15:0]};
    p2 = {{48{cal_plo[31]}}, cal_plo[31:16]};
    p3 = {{48{cal_plo[47]}}, cal_plo[47:32]};
    p4 = {{48{cal_plo[63]}}, cal_plo[63:48]};
    p5 = {{48{cal_phi[15]}}, cal_phi[15:0]};
    p6 = {{48{cal_phi[31]}}, cal_phi[31:16]};
    p7 = {{48{cal_phi[47]}}, cal_phi[47:32]};
    p8 = {{48{cal_phi[63]}}, cal_phi[63:48]};
    p9 = {{48{cal_mix[15]}}, cal_mix[15:0]};
    v1 = {{32{tfine[31]}}, tfine} - 64'd128000;
    v2 = v1 * v1 * p6 + ((v1 * p5) << 17) + (p4 << 35);
    v1 = asr64(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
    v1 = asr64(((64'd1 << 47) + v1) * p1, 33);
    r.pres = 32'd0;
    r.dz = 1'b0;
    if (v1 == 64'd0) begin
      r.dz = 1'b1;
    end else begin
      p = 64'd1048576 - {44'd0, adc_p};
      num = ((p << 31) - v2) * 64'd3125;
      p = sdiv64(num, v1);
      ps = asr64(p, 13);
      w1 = asr64(p9 * ps * ps, 25);
      w2 = asr64(p8 * p, 19);
      num = asr64(p + w1 + w2, 8) + (p7 << 4);
      r.pres = num[31:0];
    end

    adh = {16'd0, adc_h};
    h1 = {24'd0, cal_mix[23:16]};
    h2 = {{16{cal_mix[39]}}, cal_mix[39:24]};
    h3 = {24'd0, cal_mix[47:40]};
    h4 = {{20{cal_hum[11]}}, cal_hum[11:0]};
    h5 = {{20{cal_hum[23]}}, cal_hum[23:12]};
    h6 = {{24{cal_hum[31]}}, cal_hum[31:24]};
    v = tfine - 32'd76800;
    x = asr32((adh << 14) - (h4 << 20) - h5 * v + 32'd16384, 15);
    y = asr32(v * h6, 10);
    z = asr32(v * h3, 11) + 32'd32768;
    w = asr32(y * z, 10) + 32'd2097152;
    w = asr32(w * h2 + 32'd8192, 14);
    v = x * w;
    s = asr32(v, 15);
    v = v - asr32(asr32(s * s, 7) * h1, 4);
    if (v[31]) v = 32'd0;
    else if (v > 32'd419430400) v = 32'd419430400;
    r.hum = v[28:12];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] exp_v, logic [31:0] got_v);
    $display("mismatch %s: expected %h got %h", what, exp_v, got_v);
    errors++;
  endtask

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  always @(posedge clk) begin
    comp_result_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected transfer", 32'd0, out_ch.temperature_centi);
      end else begin
        e = expected_q.pop_front();
        if (out_ch.temperature_centi !== e.temp)
          report_mismatch("temperature", e.temp, out_ch.temperature_centi);
        if (out_ch.pressure_q24_8 !== e.pres)
          report_mismatch("pressure", e.pres, out_ch.pressure_q24_8);
        if (out_ch.humidity_q22_10 !== e.hum)
          report_mismatch("humidity", {15'd0, e.hum}, {15'd0, out_ch.humidity_q22_10});
        if (out_ch.divisor_zero !== e.dz)
          report_mismatch("divisor zero", {31'd0, e.dz}, {31'd0, out_ch.divisor_zero});
      end
    end
  end

  task automatic send_sample(logic [19:0] t, logic [19:0] p, logic [15:0] h);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.raw_temperature <= t;
    in_ch.raw_pressure <= p;
    in_ch.raw_humidity <= h;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_q.push_back(compensate(t, p, h));
  endtask

  task automatic drain;
    @(negedge clk);
    in_ch.valid <= 1'b0;
    wait (expected_q.size() == 0);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_cal(logic [thp_pkg::CFG_IDX_W-1:0] idx, logic [63:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      thp_pkg::CFG_TEMP_CAL:  cal_temp = data[47:0];
      thp_pkg::CFG_PRESS_LO:  cal_plo = data;
      thp_pkg::CFG_PRESS_HI:  cal_phi = data;
      thp_pkg::CFG_MIXED_CAL: cal_mix = data[47:0];
      thp_pkg::CFG_HUM_CAL:   cal_hum = data[31:0];
      default: ;
    endcase
  endtask

  task automatic load_typical_cal;
    write_cal(thp_pkg::CFG_TEMP_CAL, {16'(-16'sd1000), 16'd26435, 16'd27504});
    write_cal(thp_pkg::CFG_PRESS_LO, {16'd2855, 16'd3024, 16'(-16'sd10685), 16'd36477});
    write_cal(thp_pkg::CFG_PRESS_HI, {16'(-16'sd14600), 16'd15500, 16'(-16'sd7), 16'd140});
    write_cal(thp_pkg::CFG_MIXED_CAL, {8'd0, 16'd362, 8'd75, 16'd6000});
    write_cal(thp_pkg::CFG_HUM_CAL, {8'd30, 12'd50, 12'd313});
  endtask

  task automatic load_random_cal(bit realistic);
    if (realistic) begin
      write_cal(thp_pkg::CFG_TEMP_CAL, {16'(-16'sd1000 + $urandom_range(400) - 200),
                                        16'(26435 + $urandom_range(2000) - 1000),
                                        16'(27504 + $urandom_range(2000) - 1000)});
      write_cal(thp_pkg::CFG_PRESS_LO, {16'($urandom_range(5000)), 16'($urandom_range(5000)),
                                        16'(-16'sd10685 + $urandom_range(2000) - 1000),
                                        16'(30000 + $urandom_range(10000))});
      write_cal(thp_pkg::CFG_PRESS_HI, {16'(-16'sd14600 + $urandom_range(2000) - 1000),
                                        16'($urandom_range(20000)),
                                        16'($urandom_range(30) - 15),
                                        16'($urandom_range(300))});
      write_cal(thp_pkg::CFG_MIXED_CAL, {8'($urandom), 16'($urandom_range(500)), 8'($urandom),
                                         16'($urandom_range(10000))});
      write_cal(thp_pkg::CFG_HUM_CAL, {8'($urandom), 12'($urandom), 12'($urandom_range(600))});
    end else begin
      write_cal(thp_pkg::CFG_TEMP_CAL, {$urandom, $urandom});
      write_cal(thp_pkg::CFG_PRESS_LO, {$urandom, $urandom});
      write_cal(thp_pkg::CFG_PRESS_HI, {$urandom, $urandom});
      write_cal(thp_pkg::CFG_MIXED_CAL, {$urandom, $urandom});
      write_cal(thp_pkg::CFG_HUM_CAL, {$urandom, $urandom});
    end
  endtask

  task automatic test_zero_cal;
    send_sample(20'd0, 20'd0, 16'd0);
    send_sample(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
    drain();
  endtask

  task automatic test_typical;
    load_typical_cal();
    send_sample(20'd519888, 20'd415148, 16'd27000);
    send_sample(20'd0, 20'd0, 16'd0);
    send_sample(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
    send_sample(20'd519888, 20'd0, 16'hFFFF);
    send_sample(20'd519888, 20'hFFFFF, 16'd0);
    send_sample(20'hAAAAA, 20'h55555, 16'hAAAA);
    send_sample(20'h55555, 20'hAAAAA, 16'h5555);
    drain();
  endtask

  task automatic test_extreme_cal;
    write_cal(CFG_UNUSED_IDX, 64'hFFFF_FFFF_FFFF_FFFF);
    write_cal(thp_pkg::CFG_TEMP_CAL, 64'hFFFF_FFFF_FFFF_FFFF);
    write_cal(thp_pkg::CFG_PRESS_LO, 64'hFFFF_FFFF_FFFF_FFFF);
    write_cal(thp_pkg::CFG_PRESS_HI, 64'hFFFF_FFFF_FFFF_FFFF);
    write_cal(thp_pkg::CFG_MIXED_CAL, 64'hFFFF_FFFF_FFFF_FFFF);
    write_cal(thp_pkg::CFG_HUM_CAL, 64'hFFFF_FFFF_FFFF_FFFF);
    send_sample(20'd0, 20'd0, 16'd0);
    send_sample(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
    send_sample(20'd519888, 20'd415148, 16'd27000);
    drain();
    write_cal(thp_pkg::CFG_TEMP_CAL, 64'h8000_8000);
    write_cal(thp_pkg::CFG_PRESS_LO, 64'h8000_8000_8000_0000);
    write_cal(thp_pkg::CFG_PRESS_HI, 64'h7FFF_7FFF_7FFF_7FFF);
    write_cal(thp_pkg::CFG_MIXED_CAL, 64'hFF7F_FFFF_7FFF);
    write_cal(thp_pkg::CFG_HUM_CAL, 64'h7F7F_F800);
    send_sample(20'd0, 20'hFFFFF, 16'hFFFF);
    send_sample(20'hFFFFF, 20'd0, 16'd0);
    send_sample(20'h80000, 20'h80000, 16'h8000);
    drain();
  endtask

  task automatic test_random;
    int src_pct[4] = '{0, 51, 0, 26};
    int snk_pct[4] = '{0, 0, 51, 26};
    logic [19:0] t, p;
    logic [15:0] h;
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 7) load_typical_cal();
      else load_random_cal(ph % 3 != 2);
      src_idle_pct = src_pct[ph % 4];
      snk_stall_pct = snk_pct[ph % 4];
      for (int i = 0; i < 200; i++) begin
        if ($urandom_range(3) != 0) begin
          t = 20'(400000 + $urandom_range(200000));
          p = 20'(250000 + $urandom_range(300000));
          h = 16'(15000 + $urandom_range(40000));
        end else begin
          t = 20'($urandom);
          p = 20'($urandom);
          h = 16'($urandom);
        end
        send_sample(t, p, h);
        if (i == 100 && ph == 1) begin
          @(negedge clk);
          in_ch.valid <= 1'b0;
          wait (expected_q.size() == 0);
        end
      end
      drain();
    end
    src_idle_pct = 0;
    snk_stall_pct = 0;
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.raw_temperature = '0;
    in_ch.raw_pressure = '0;
    in_ch.raw_humidity = '0;
    out_ch.ready = 1'b0;
    cal_temp = '0;
    cal_plo = '0;
    cal_phi = '0;
    cal_mix = '0;
    cal_hum = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_zero_cal();
    test_typical();
    test_extreme_cal();
    test_random();
    drain();
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: thp_sensor_compensation_core.f
hw/rtl/thp_pkg.sv
hw/rtl/thp_if.sv
hw/rtl/thp_front.sv
hw/rtl/thp_queue.sv
hw/rtl/thp_div.sv
hw/rtl/thp_back.sv
hw/rtl/thp_sensor_compensation_core.sv
hw/rtl/thp_checker.sv
tb/sv/tb_thp_sensor_compensation_core.sv
